[sv/decimal32_string_parser_assert.svh]
// ----------------------------------------------------------------------------
// decimal32_string_parser assertion macros
// Shared property shorthands for the checker of the text to decimal32 parser.
// ----------------------------------------------------------------------------
`ifndef DECIMAL32_STRING_PARSER_ASSERT_SVH
`define DECIMAL32_STRING_PARSER_ASSERT_SVH

// The consequent must hold on the edge after the antecedent.
`define D32SP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold on the same edge as the antecedent.
`define D32SP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checked on the edge after a reset edge, so reset itself is not disabled.
`define D32SP_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

[sv/d32sp_pkg.sv]
// ----------------------------------------------------------------------------
// d32sp_pkg
// Types and constants shared by the decimal32 string parser modules.
// ----------------------------------------------------------------------------
package d32sp_pkg;

  localparam int CountBitsDef = 16;
  localparam int KeepDigits   = 7;
  localparam int InDataW      = 8;
  localparam int OutDataW     = 56;
  localparam int CountOutW    = 16;

  localparam logic [16:0] ExpBias      = 17'd101;
  localparam logic [16:0] ExpMaxBiased = 17'd191;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [0:0] ModeBid = 1'b0;
  localparam logic [0:0] ModeDpd = 1'b1;

  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_LZERO = 6'b000010,
    ST_INT   = 6'b000100,
    ST_FRAC  = 6'b001000,
    ST_CONV  = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_t;

  typedef struct packed {
    logic set_neg;
    logic keep;
    logic exp_inc;
    logic exp_dec;
    logic count_inc;
    logic terminate;
    logic conv_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_minus;
    logic is_zero;
    logic is_digit;
    logic is_dot;
    logic room;
    logic conv_last;
    logic out_busy;
  } status_t;

endpackage

[sv/decimal32_string_parser.sv]
// ----------------------------------------------------------------------------
// decimal32_string_parser
// Streams ASCII decimal text in and emits one decimal32 word per number.
//
// Channel  Direction  Contents
// in_      slave      one ASCII character per transaction
// out_     master     decimal32 word, consumed count, exponent range flag
// cfg_     write      encoding mode (0 BID, 1 DPD)
//
// Sign, digit and point characters are accepted back to back, without a stall.
// The terminating character starts a digit-serial conversion of the seven kept
// digits (one BCD digit per cycle into the binary significand) and a load step;
// in_tready is low through both, longer if the result register
// is still full. Reset clears the parser and selects BID encoding.
// A pending result does not block the characters of the next number.
// ----------------------------------------------------------------------------
module decimal32_string_parser #(
  parameter int COUNT_BITS = d32sp_pkg::CountBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,  // encoding_mode
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [d32sp_pkg::InDataW-1:0]  in_tdata,     // [7:0] ch
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] encoded_word, [47:32] consumed_count, [48] exponent_out_of_range
  output logic [d32sp_pkg::OutDataW-1:0] out_tdata
);
  import d32sp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  d32sp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  d32sp_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

[sv/d32sp_ctrl.sv]
// ----------------------------------------------------------------------------
// d32sp_ctrl
// Parse phase and conversion sequencing for the decimal32 string parser.
// ----------------------------------------------------------------------------
module d32sp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  d32sp_pkg::status_t sts,
  output d32sp_pkg::cmd_t    cmd
);
  import d32sp_pkg::*;

  state_t state_r, state_nxt;
  logic   parsing;
  logic   acc;

  assign parsing   = (state_r == ST_START) || (state_r == ST_LZERO) ||
                     (state_r == ST_INT) || (state_r == ST_FRAC);
  assign in_tready = parsing;
  assign acc       = in_tvalid && parsing;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_START, ST_LZERO, ST_INT, ST_FRAC: begin
        if (acc) begin
          if ((state_r == ST_START) && sts.is_minus) begin
            cmd.set_neg   = 1'b1;
            cmd.count_inc = 1'b1;
            state_nxt     = ST_LZERO;
          end else if (((state_r == ST_START) || (state_r == ST_LZERO)) && sts.is_zero) begin
            cmd.count_inc = 1'b1;
            state_nxt     = ST_LZERO;
          end else if (sts.is_digit && (state_r != ST_FRAC)) begin
            cmd.count_inc = 1'b1;
            cmd.keep      = sts.room;
            cmd.exp_inc   = !sts.room;
            state_nxt     = ST_INT;
          end else if (sts.is_digit) begin
            // Fraction digits past the kept seven are dropped; they only add to the consumed count.
            cmd.count_inc = 1'b1;
            cmd.keep      = sts.room;
            cmd.exp_dec   = sts.room;
          end else if (sts.is_dot && (state_r != ST_FRAC)) begin
            cmd.count_inc = 1'b1;
            state_nxt     = ST_FRAC;
          end else begin
            cmd.terminate = 1'b1;
            state_nxt     = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_START;
        end
      end
      default: begin
        state_nxt = ST_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/d32sp_dpath.sv]
// ----------------------------------------------------------------------------
// d32sp_dpath
// Parser registers, significand conversion and result register.
// ----------------------------------------------------------------------------
module d32sp_dpath #(
  parameter int COUNT_BITS = d32sp_pkg::CountBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic [d32sp_pkg::InDataW-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [d32sp_pkg::OutDataW-1:0] out_tdata,
  input  d32sp_pkg::cmd_t                cmd,
  output d32sp_pkg::status_t             sts
);
  import d32sp_pkg::*;

  localparam int WideW = (COUNT_BITS > CountOutW) ? COUNT_BITS : CountOutW;

  logic                  mode_r;
  logic [27:0]           bcd_r;
  logic [2:0]            left_r;
  logic signed [15:0]    exp_r;
  logic                  neg_r;
  logic [COUNT_BITS-1:0] count_r;

  logic [27:0]           snap_bcd_r;
  logic [27:0]           shift_r;
  logic                  snap_neg_r;
  logic [7:0]            snap_e_r;
  logic                  snap_bad_r;
  logic [CountOutW-1:0]  snap_count_r;
  logic                  snap_mode_r;
  logic [23:0]           mant_r;
  logic [2:0]            idx_r;

  logic                  out_valid_r;
  logic [31:0]           out_word_r;
  logic [CountOutW-1:0]  out_count_r;
  logic                  out_flag_r;

  logic signed [16:0]    biased;
  logic [WideW-1:0]      count_wide;
  logic [CountOutW-1:0]  count_sat;
  logic [31:0]           word_bid;
  logic [31:0]           word_dpd;
  logic [3:0]            top;

  function automatic logic [9:0] declet(input logic [11:0] x);
    logic [2:0] sel;
    logic [2:0] bcd, fgh, jkm;
    logic       d, h, m;
    logic [1:0] fg, jk;
    logic [9:0] r;
    sel = {x[11], x[7], x[3]};
    bcd = x[10:8];
    fgh = x[6:4];
    jkm = x[2:0];
    d   = x[8];
    h   = x[4];
    m   = x[0];
    fg  = x[6:5];
    jk  = x[2:1];
    case (sel)
      3'd0:    r = {bcd, fgh, 1'b0, jkm};
      3'd1:    r = {bcd, fgh, 3'b100, m};
      3'd2:    r = {bcd, jk, h, 3'b101, m};
      3'd3:    r = {bcd, 2'b10, h, 3'b111, m};
      3'd4:    r = {jk, d, fgh, 3'b110, m};
      3'd5:    r = {fg, d, 2'b01, h, 3'b111, m};
      3'd6:    r = {jk, d, 2'b00, h, 3'b111, m};
      default: r = {2'b00, d, 2'b11, h, 3'b111, m};
    endcase
    return r;
  endfunction

  // Character classes and status flags.
  assign sts.is_minus  = (in_tdata == ChMinus);
  assign sts.is_zero   = (in_tdata == ChZero);
  assign sts.is_digit  = (in_tdata >= ChZero) && (in_tdata <= ChNine);
  assign sts.is_dot    = (in_tdata == ChDot);
  assign sts.room      = (left_r != 3'd0);
  assign sts.conv_last = (idx_r == 3'(KeepDigits - 1));
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign biased     = 17'(signed'(exp_r)) + signed'(ExpBias);
  assign count_wide = WideW'(count_r);
  assign count_sat  = (count_wide > WideW'({CountOutW{1'b1}})) ? {CountOutW{1'b1}}
                                                              : count_wide[CountOutW-1:0];

  // Encodings from the conversion registers.
  assign top = snap_bcd_r[27:24];

  always_comb begin
    if (mant_r[23]) begin
      word_bid = {snap_neg_r, 2'b11, snap_e_r, mant_r[20:0]};
    end else begin
      word_bid = {snap_neg_r, snap_e_r, mant_r[22:0]};
    end
    if (top[3]) begin
      word_dpd = {snap_neg_r, 2'b11, snap_e_r[7:6], top[0], snap_e_r[5:0],
                  declet(snap_bcd_r[23:12]), declet(snap_bcd_r[11:0])};
    end else begin
      word_dpd = {snap_neg_r, snap_e_r[7:6], top[2:0], snap_e_r[5:0],
                  declet(snap_bcd_r[23:12]), declet(snap_bcd_r[11:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ModeBid;
      bcd_r   <= '0;
      left_r  <= 3'(KeepDigits);
      exp_r   <= '0;
      neg_r   <= 1'b0;
      count_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.terminate) begin
        bcd_r   <= '0;
        left_r  <= 3'(KeepDigits);
        exp_r   <= '0;
        neg_r   <= 1'b0;
        count_r <= '0;
      end else begin
        if (cmd.set_neg) begin
          neg_r <= 1'b1;
        end
        if (cmd.keep) begin
          bcd_r  <= {bcd_r[23:0], in_tdata[3:0]};
          left_r <= left_r - 3'd1;
        end
        if (cmd.exp_inc && (exp_r != 16'sh7FFF)) begin
          exp_r <= exp_r + 16'sd1;
        end
        if (cmd.exp_dec && (exp_r != -16'sh8000)) begin
          exp_r <= exp_r - 16'sd1;
        end
        if (cmd.count_inc && (count_r != {COUNT_BITS{1'b1}})) begin
          count_r <= count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  // Conversion registers carry no reset: they are loaded before use.
  always_ff @(posedge clk) begin
    if (cmd.terminate) begin
      snap_bcd_r   <= bcd_r;
      shift_r      <= bcd_r;
      snap_neg_r   <= neg_r;
      snap_e_r     <= biased[7:0];
      snap_bad_r   <= biased[16] || (biased > signed'(ExpMaxBiased));
      snap_count_r <= count_sat;
      snap_mode_r  <= mode_r;
      mant_r       <= '0;
      idx_r        <= '0;
    end else if (cmd.conv_step) begin
      // One decimal digit per cycle: mant * 10 + digit.
      mant_r  <= (mant_r << 3) + (mant_r << 1) + 24'(shift_r[27:24]);
      shift_r <= {shift_r[23:0], 4'd0};
      idx_r   <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r  <= (snap_mode_r == ModeDpd) ? word_dpd : word_bid;
      out_count_r <= snap_count_r;
      out_flag_r  <= snap_bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_flag_r, out_count_r, out_word_r};

endmodule

[sv/d32sp_checker.sv]
// ----------------------------------------------------------------------------
// d32sp_checker
// Port-level checks for the decimal32 string parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "decimal32_string_parser_assert.svh"

module d32sp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  import d32sp_pkg::*;

  logic in_acc;
  logic in_term;

  assign in_acc  = in_tvalid && in_tready;
  assign in_term = !((in_tdata >= ChZero) && (in_tdata <= ChNine)) &&
                   (in_tdata != ChDot) && (in_tdata != ChMinus);

  `D32SP_ASSERT_NEXT(a_out_hold, clk, rst_n,
                     out_tvalid && !out_tready,
                     out_tvalid && $stable(out_tdata),
                     "result changed while stalled")
  `D32SP_ASSERT_NEXT(a_term_busy, clk, rst_n,
                     in_acc && in_term,
                     !in_tready,
                     "input still ready after a terminating character")
  `D32SP_ASSERT_SAME(a_pad_zero, clk, rst_n,
                     out_tvalid,
                     out_tdata[55:49] == 7'd0,
                     "padding bits of the result are not zero")
  `D32SP_ASSERT_AFTER_RESET(a_reset_state, clk, rst_n,
                            in_tready && !out_tvalid,
                            "wrong handshake state after reset")

endmodule

bind decimal32_string_parser d32sp_checker u_d32sp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/decimal32_string_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal32_string_parser_tb
// Streams decimal text into the parser under bursty input and a stalling
// output, predicts every decimal32 result in both encodings and checks
// each output transaction field by field in order.
// ----------------------------------------------------------------------------
module decimal32_string_parser_tb;
  import d32sp_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int SettleTicks = 16;
  localparam int IdleLimit   = 1000;
  localparam int RandomChars = 640;
  localparam int LongDigits  = 100;
  localparam int CountMax    = (1 << CountBitsDef) - 1;

  typedef enum logic [1:0] {TXT_SIGN, TXT_LZERO, TXT_INT, TXT_FRAC} text_phase_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_style_t;

  typedef struct packed {
    logic [31:0] word;
    logic [15:0] count;
    logic        over;
  } d32_result_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  decimal32_string_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #HalfPeriod clk = ~clk;

  // Text waiting to be sent and decimal32 results waiting to come back.
  logic [7:0]  text_queue[$];
  d32_result_t pending_words[$];
  int          error_count = 0;

  // Predicted parser state and the encoding currently programmed.
  logic [0:0]  enc_mode = ModeBid;
  text_phase_t txt_phase;
  logic [27:0] bcd_acc;
  int          digits_free;
  int          exp_acc;
  logic        neg_flag;
  int          char_total;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 50) begin
      $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
    error_count++;
  endtask

  function automatic logic [9:0] dpd_declet(input logic [11:0] x);
    logic [3:0] a, b, c;
    a = x[11:8];
    b = x[7:4];
    c = x[3:0];
    // Select the table row by which of the three digits are 8 or 9.
    case ({a[3], b[3], c[3]})
      3'b000: return {a[2:0], b[2:0], 1'b0, c[2:0]};
      3'b001: return {a[2:0], b[2:0], 3'b100, c[0]};
      3'b010: return {a[2:0], c[2:1], b[0], 3'b101, c[0]};
      3'b100: return {c[2:1], a[0], b[2:0], 3'b110, c[0]};
      3'b011: return {a[2:0], 2'b10, b[0], 3'b111, c[0]};
      3'b101: return {b[2:1], a[0], 2'b01, b[0], 3'b111, c[0]};
      3'b110: return {c[2:1], a[0], 2'b00, b[0], 3'b111, c[0]};
      default: return {2'b00, a[0], 2'b11, b[0], 3'b111, c[0]};
    endcase
  endfunction

  function automatic int clamp_exp(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advances the predicted parser by one character. Returns 1 with the
  // expected result when the character ends the number.
  function automatic bit track_char(input logic [7:0] c, output d32_result_t r);
    bit          is_digit;
    bit          take;
    int          biased;
    logic [7:0]  e;
    logic [31:0] w;
    logic [23:0] mant;
    logic [3:0]  top;
    is_digit = (c >= ChZero) && (c <= ChNine);
    take = 1'b1;
    r = '0;
    if (txt_phase == TXT_SIGN && c == ChMinus) begin
      neg_flag = 1'b1;
      txt_phase = TXT_LZERO;
    end else if ((txt_phase == TXT_SIGN || txt_phase == TXT_LZERO) && c == ChZero) begin
      txt_phase = TXT_LZERO;
    end else if (is_digit && txt_phase != TXT_FRAC) begin
      txt_phase = TXT_INT;
      if (digits_free > 0) begin
        bcd_acc = {bcd_acc[23:0], c[3:0]};
        digits_free--;
      end else begin
        exp_acc = clamp_exp(exp_acc + 1);
      end
    end else if (is_digit) begin
      // Fraction digits past the seventh kept one are dropped but still counted.
      if (digits_free > 0) begin
        bcd_acc = {bcd_acc[23:0], c[3:0]};
        digits_free--;
        exp_acc = clamp_exp(exp_acc - 1);
      end
    end else if (c == ChDot && txt_phase != TXT_FRAC) begin
      txt_phase = TXT_FRAC;
    end else begin
      take = 1'b0;
    end

    if (take) begin
      if (char_total < CountMax) char_total++;
      return 1'b0;
    end

    biased = exp_acc + int'(ExpBias);
    e = biased[7:0];
    w = '0;
    w[31] = neg_flag;
    if (enc_mode == ModeBid) begin
      mant = '0;
      for (int i = KeepDigits - 1; i >= 0; i--) begin
        mant = 24'(mant * 10 + bcd_acc[4*i +: 4]);
      end
      if (mant[23]) w[30:0] = {2'b11, e, mant[20:0]};
      else w[30:0] = {e, mant[22:0]};
    end else begin
      top = bcd_acc[27:24];
      if (top[3]) w[30:26] = {2'b11, e[7:6], top[0]};
      else w[30:26] = {e[7:6], top[2:0]};
      w[25:20] = e[5:0];
      w[19:10] = dpd_declet(bcd_acc[23:12]);
      w[9:0]   = dpd_declet(bcd_acc[11:0]);
    end
    r.word  = w;
    r.count = char_total[15:0];
    r.over  = (biased < 0) || (biased > int'(ExpMaxBiased));

    txt_phase = TXT_SIGN;
    bcd_acc = '0;
    digits_free = KeepDigits;
    exp_acc = 0;
    neg_flag = 1'b0;
    char_total = 0;
    return 1'b1;
  endfunction

  // Output results are checked before the input side is tracked: a result
  // can never belong to a terminator accepted on the same edge.
  always @(posedge clk) begin : monitor_proc
    d32_result_t got;
    d32_result_t want;
    d32_result_t fresh;
    if (!rst_n) begin
      txt_phase = TXT_SIGN;
      bcd_acc = '0;
      digits_free = KeepDigits;
      exp_acc = 0;
      neg_flag = 1'b0;
      char_total = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.word  = out_tdata[31:0];
        got.count = out_tdata[47:32];
        got.over  = out_tdata[48];
        if (pending_words.size() == 0) begin
          report_mismatch("result with none expected", got.word, '0);
        end else begin
          want = pending_words.pop_front();
          if (got.word !== want.word) report_mismatch("encoded word", got.word, want.word);
          if (got.count !== want.count) begin
            report_mismatch("consumed count", 32'(got.count), 32'(want.count));
          end
          if (got.over !== want.over) begin
            report_mismatch("exponent range flag", 32'(got.over), 32'(want.over));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (track_char(in_tdata, fresh)) pending_words.push_back(fresh);
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int gap_left   = 0;
  int burst_left = 0;

  function automatic int next_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      3: return $urandom_range(5, 20);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (text_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= text_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= next_gap();
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a style is drawn each time the 6-bit tick counter wraps, from always ready to long
  // blocked stretches.
  logic [5:0] rx_tick  = '0;
  rx_style_t  rx_style = RX_OPEN;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_tick    <= '0;
      rx_style   <= RX_OPEN;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick == '1) rx_style <= rx_style_t'($urandom_range(0, 3));
      case (rx_style)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= (rx_tick[1:0] == 2'b00);
        default:   out_tready <= (rx_tick[4:3] == 2'b00);
      endcase
    end
  end

  // Watchdog on cycles without any transaction.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int chars_queued = 0;

  task automatic push_char(input logic [7:0] c);
    text_queue.push_back(c);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] pick_terminator();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= ChZero && c <= ChNine) || c == ChDot || c == ChMinus) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Digits 8 and 9 are favored so the large-digit encodings come up often.
  function automatic logic [7:0] pick_digit();
    if ($urandom_range(0, 3) == 0) return ChZero + 8'($urandom_range(8, 9));
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  task automatic wait_drained();
    while (text_queue.size() != 0 || in_tvalid || pending_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_encoding(input logic [0:0] mode);
    wait_drained();
    repeat (SettleTicks) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    enc_mode = mode;
  endtask

  task automatic push_directed();
    push_char(8'h00);                        // empty number
    push_text("-");       push_char(8'hFF);  // negative zero
    push_text("000");     push_char(" ");
    push_text("-0.000");  push_char("e");
    push_text("1234567"); push_char(",");
    push_text("9999999"); push_char(8'h7F);  // BID significand past 2^23
    push_text("8090807"); push_char(8'h80);  // DPD leading digit 8
    push_text("12345678901");  push_char("+");
    push_text("0.0012345678"); push_char("/");
    push_text(".5");      push_char(":");
    push_text("--");                         // second minus ends the number
    push_text("1.2.3");   push_char("x");    // second point ends the number
  endtask

  task automatic push_random_number();
    int n_lead, n_int, n_frac;
    n_lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    n_int  = ($urandom_range(0, 15) == 0) ? $urandom_range(80, 110) : $urandom_range(0, 10);
    n_frac = 0;
    if ($urandom_range(0, 1)) push_char(ChMinus);
    repeat (n_lead) push_char(ChZero);
    repeat (n_int) push_char(pick_digit());
    if ($urandom_range(0, 2) != 0) begin
      push_char(ChDot);
      n_frac = $urandom_range(0, 10);
    end
    repeat (n_frac) push_char(pick_digit());
    push_char(pick_terminator());
  endtask

  // Mostly well-formed numbers; the rest is arbitrary bytes that may break
  // a number in any state. Always closed by a terminator.
  task automatic push_random_text(input int n_chars);
    int goal;
    goal = chars_queued + n_chars;
    while (chars_queued < goal) begin
      if ($urandom_range(0, 6) != 0) begin
        push_random_number();
      end else begin
        repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
      end
    end
    push_char(pick_terminator());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_encoding(ModeBid);
    push_directed();
    set_encoding(ModeDpd);
    push_directed();

    for (int ph = 0; ph < 4; ph++) begin
      set_encoding((ph % 2 == 0) ? ModeBid : ModeDpd);
      if (ph == 0) begin
        push_random_text(RandomChars / 8);
        // Hold the input back until the output side has fully caught up.
        wait_drained();
        push_random_text(RandomChars / 8);
      end else begin
        push_random_text(RandomChars / 4);
      end
    end

    // One long number pushes the biased exponent past the top of its range.
    set_encoding(ModeDpd);
    push_text("-1");
    repeat (LongDigits) push_char(ChZero + 8'($urandom_range(0, 9)));
    push_char(pick_terminator());

    wait_drained();
    repeat (SettleTicks) @(negedge clk);
    if (pending_words.size() != 0) begin
      report_mismatch("results missing", pending_words.size(), '0);
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/d32sp_pkg.sv
sv/d32sp_ctrl.sv
sv/d32sp_dpath.sv
sv/decimal32_string_parser.sv
sv/d32sp_checker.sv
test/decimal32_string_parser_tb.sv
